// ----- rtl/rsp_pkg.sv -----
// Shared constants and types for the ray versus sphere or plane intersection core.
// It depends on nothing. The core, front, queue, back end and checker use it.
package rsp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int EPS_WIDTH       = 16;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd7;
  localparam int FIFO_DEPTH      = 4;

  localparam logic OP_SPHERE = 1'b0;
  localparam logic OP_PLANE  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- rtl/ray_sphere_plane_intersect_core.sv -----
// Ray versus unit sphere or plane y = 0 intersection core, top level.
// It depends on rsp_pkg, rsp_front, rsp_fifo and rsp_back.
//
// The core takes one ray per clock cycle while in_ready is high. A plane hit
// gives one result and a sphere hit gives two (t0, then t1 with last set);
// misses give none. Results leave through one output register at one per
// cycle while out_ready allows. A sphere hit holds the single divider issue
// slot for both of its results, so the next queue entry waits behind it. A
// ray passes the front pipeline (products, discriminant, one root bit per
// stage), the queue, and the divider, which resolves one quotient bit per
// stage. The epsilon register is written through the configuration channel,
// which is always ready.
module ray_sphere_plane_intersect_core #(
  parameter int COORD_WIDTH = rsp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rsp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] t_value,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsp_pkg::EPS_WIDTH-1:0] cfg_data
);

  import rsp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int EW = 1 + (2 * W + 1) + (W + F) + 2 * W;

  logic [EPS_WIDTH-1:0] epsilon;
  fifo_status_t         status;
  logic                 fo_valid, pop;
  logic [EW-1:0]        fo_entry, head_entry;
  logic [W-1:0]         t_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_valid) begin
      epsilon <= cfg_data;
    end
  end

  rsp_front #(.W(W), .F(F)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .epsilon  (epsilon),
    .status   (status),
    .fo_valid (fo_valid),
    .fo_entry (fo_entry)
  );

  rsp_fifo #(.EW(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (fo_valid),
    .din    (fo_entry),
    .pop    (pop),
    .dout   (head_entry),
    .status (status)
  );

  rsp_back #(.W(W), .F(F)) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (head_entry),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .t_value   (t_bits),
    .last      (last)
  );

  assign t_value = t_bits;

endmodule

// ----- rtl/rsp_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
// It depends on nothing beyond its parameter.
module rsp_mul #(
  parameter int N = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N-1:0]   a,
  input  logic [N-1:0]   b,
  output logic [2*N-1:0] p
);

  localparam int H  = (N + 1) / 2;
  localparam int U  = N - H;
  localparam int PW = 2 * N;

  logic [2*H-1:0] pll;
  logic [N-1:0]   plh;
  logic [N-1:0]   phl;
  logic [2*U-1:0] phh;
  logic [PW-1:0]  sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
      plh <= N'(a[H-1:0]) * N'(b[N-1:H]);
      phl <= N'(a[N-1:H]) * N'(b[H-1:0]);
      phh <= (2*U)'(a[N-1:H]) * (2*U)'(b[N-1:H]);
    end
  end

  assign sum = PW'(pll) + (PW'(plh) << H) + (PW'(phl) << H) + (PW'(phh) << (2 * H));

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum;
    end
  end

endmodule

// ----- rtl/rsp_sqrt.sv -----
// Pipelined integer floor square root, one result bit per stage, with a side payload.
// It depends on nothing beyond its parameters.
module rsp_sqrt #(
  parameter int R  = 48,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*R-1:0]  x,
  input  logic [PW-1:0]   pay_in,
  output logic            out_valid,
  output logic [R-1:0]    root_out,
  output logic [PW-1:0]   pay_out
);

  localparam int DW = 2 * R;

  logic [DW-1:0] rem  [0:R];
  logic [R-1:0]  root [0:R];
  logic [PW-1:0] pay  [0:R];
  logic [R:0]    vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= x;
      root[0] <= '0;
      pay[0]  <= pay_in;
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_stage
    localparam int I = R - 1 - k;
    logic [DW-1:0] trial;
    logic          take;

    assign trial = (DW'(root[k]) << (I + 1)) | (DW'(1) << (2 * I));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        root[k+1] <= take ? (root[k] | (R'(1) << I)) : root[k];
        pay[k+1]  <= pay[k];
      end
    end
  end

  assign out_valid = vld[R];
  assign root_out  = root[R];
  assign pay_out   = pay[R];

endmodule

// ----- rtl/rsp_front.sv -----
// Front end: takes rays, forms a, half-b and the discriminant, drops misses, takes the root.
// It depends on rsp_pkg, rsp_mul and rsp_sqrt.
module rsp_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [W-1:0]                  origin_x,
  input  logic [W-1:0]                  origin_y,
  input  logic [W-1:0]                  origin_z,
  input  logic [W-1:0]                  dir_x,
  input  logic [W-1:0]                  dir_y,
  input  logic [W-1:0]                  dir_z,
  input  logic [rsp_pkg::EPS_WIDTH-1:0] epsilon,
  input  rsp_pkg::fifo_status_t         status,
  output logic                          fo_valid,
  output logic [1+(2*W+1)+(W+F)+2*W-1:0] fo_entry
);

  import rsp_pkg::*;

  localparam int AW = 2 * W;
  localparam int HW = 2 * W + 1;
  localparam int SW = 4 * W;
  localparam int DW = 2 * W + 2 * F;
  localparam int R  = W + F;
  localparam int XW = ((SW > DW) ? SW : DW) + 1;
  localparam int TW = (AW > EPS_WIDTH + F) ? AW : EPS_WIDTH + F;
  localparam int PW = 2 + HW + AW;
  localparam int NP = 12;
  localparam int MA [NP] = '{3, 4, 5, 3, 4, 5, 4, 5, 5, 3, 3, 4};
  localparam int MB [NP] = '{3, 4, 5, 0, 1, 2, 2, 1, 0, 2, 1, 0};

  logic          fen;
  logic [9:0]    vld;
  logic [W-1:0]  cin  [6];
  logic [W-1:0]  cmag [6];
  logic [HW-1:0] oyx;
  logic          pok_in;

  logic          op0, op1, op2, op3, op4;
  logic [W-1:0]  m0 [6];
  logic [5:0]    g0;
  logic [HW-1:0] pnh0, pnh1, pnh2, pnh3, pnh4;
  logic [W-1:0]  pden0, pden1, pden2, pden3, pden4;
  logic          pok0, pok1, pok2, pok3, pok4;
  logic [NP-1:0] ps1, ps2;
  logic [AW-1:0] p2 [NP];
  logic [AW-1:0] a3, a4;
  logic [HW-1:0] sp3 [9];
  logic [HW-1:0] h4;
  logic [HW-1:0] cr4 [3];
  logic          aok4;
  logic [AW-1:0] cm5 [3];
  logic [SW-1:0] bs7 [3];
  logic          sph5, sph6, sph7, sph8, sph9;
  logic          ok5, ok6, ok7, ok8;
  logic [HW-1:0] nh5, nh6, nh7, nh8, nh9;
  logic [AW-1:0] den5, den6, den7, den8, den9;
  logic [SW-1:0] sq8;
  logic [XW-1:0] disc;
  logic          keep9;
  logic [DW-1:0] dx9;

  logic          sq_valid;
  logic [R-1:0]  sq_root;
  logic [PW-1:0] sq_pay;

  assign cin[0] = origin_x;
  assign cin[1] = origin_y;
  assign cin[2] = origin_z;
  assign cin[3] = dir_x;
  assign cin[4] = dir_y;
  assign cin[5] = dir_z;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      cmag[i] = cin[i][W-1] ? (~cin[i] + 1'b1) : cin[i];
    end
  end

  assign oyx    = {{(HW-W){origin_y[W-1]}}, origin_y};
  assign pok_in = (cmag[4] != '0) && (cmag[4] >= W'(epsilon));

  assign fen      = !(fo_valid && status.full);
  assign in_ready = fen;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (fen) begin
      vld <= {vld[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      op0 <= operation;
      for (int i = 0; i < 6; i++) begin
        m0[i] <= cmag[i];
        g0[i] <= cin[i][W-1];
      end
      pnh0  <= dir_y[W-1] ? oyx : (HW'(0) - oyx);
      pden0 <= cmag[4];
      pok0  <= pok_in;
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_mul
    rsp_mul #(.N(W)) u_mul (
      .clk (clk),
      .en  (fen),
      .a   (m0[MA[g]]),
      .b   (m0[MB[g]]),
      .p   (p2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int k = 0; k < NP; k++) begin
        ps1[k] <= g0[MA[k]] ^ g0[MB[k]];
      end
      op1   <= op0;
      pnh1  <= pnh0;
      pden1 <= pden0;
      pok1  <= pok0;
      ps2   <= ps1;
      op2   <= op1;
      pnh2  <= pnh1;
      pden2 <= pden1;
      pok2  <= pok1;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      a3 <= p2[0] + p2[1] + p2[2];
      for (int k = 0; k < 9; k++) begin
        sp3[k] <= ps2[k+3] ? (HW'(0) - HW'(p2[k+3])) : HW'(p2[k+3]);
      end
      op3   <= op2;
      pnh3  <= pnh2;
      pden3 <= pden2;
      pok3  <= pok2;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      h4     <= sp3[0] + sp3[1] + sp3[2];
      cr4[0] <= sp3[3] - sp3[4];
      cr4[1] <= sp3[5] - sp3[6];
      cr4[2] <= sp3[7] - sp3[8];
      a4     <= a3;
      aok4   <= (a3 != '0) && (TW'(a3) >= (TW'(epsilon) << F));
      op4    <= op3;
      pnh4   <= pnh3;
      pden4  <= pden3;
      pok4   <= pok3;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 3; i++) begin
        cm5[i] <= cr4[i][HW-1] ? AW'(HW'(0) - cr4[i]) : AW'(cr4[i]);
      end
      sph5 <= op4 == OP_SPHERE;
      nh5  <= (op4 == OP_SPHERE) ? (HW'(0) - h4) : pnh4;
      den5 <= (op4 == OP_SPHERE) ? a4 : AW'(pden4);
      ok5  <= (op4 == OP_SPHERE) ? aok4 : pok4;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sq
    rsp_mul #(.N(AW)) u_sq (
      .clk (clk),
      .en  (fen),
      .a   (cm5[g]),
      .b   (cm5[g]),
      .p   (bs7[g])
    );
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      sph6 <= sph5;
      ok6  <= ok5;
      nh6  <= nh5;
      den6 <= den5;
      sph7 <= sph6;
      ok7  <= ok6;
      nh7  <= nh6;
      den7 <= den6;
      sq8  <= bs7[0] + bs7[1] + bs7[2];
      sph8 <= sph7;
      ok8  <= ok7;
      nh8  <= nh7;
      den8 <= den7;
    end
  end

  assign disc = (XW'(den8) << (2 * F)) - XW'(sq8);

  always_ff @(posedge clk) begin
    if (fen) begin
      keep9 <= ok8 && (!sph8 || !disc[XW-1]);
      dx9   <= sph8 ? disc[DW-1:0] : '0;
      sph9  <= sph8;
      nh9   <= nh8;
      den9  <= den8;
    end
  end

  rsp_sqrt #(.R(R), .PW(PW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (fen),
    .in_valid  (vld[9]),
    .x         (dx9),
    .pay_in    ({keep9, sph9, nh9, den9}),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .pay_out   (sq_pay)
  );

  assign fo_valid = sq_valid && sq_pay[PW-1];
  assign fo_entry = {sq_pay[PW-2], sq_pay[PW-3 -: HW], sq_root, sq_pay[AW-1:0]};

endmodule

// ----- rtl/rsp_fifo.sv -----
// Short register queue that parts the front end from the divider back end.
// It depends on rsp_pkg for the status struct.
module rsp_fifo #(
  parameter int EW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [EW-1:0]         din,
  input  logic                  pop,
  output logic [EW-1:0]         dout,
  output rsp_pkg::fifo_status_t status
);

  import rsp_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [EW-1:0]   mem [DEPTH];
  logic [PTRW-1:0] head, tail;
  logic [CNTW-1:0] count;
  logic            do_push, do_pop;

  assign status.full  = count == CNTW'(DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTRW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTRW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= din;
    end
  end

endmodule

// ----- rtl/rsp_back.sv -----
// Back end: issues one quotient per free cycle from the queue to a pipelined rounding divider.
// It depends on rsp_pkg for the queue status struct.
module rsp_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1+(2*W+1)+(W+F)+2*W-1:0] entry,
  input  rsp_pkg::fifo_status_t          status,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [W-1:0]                   t_value,
  output logic                           last
);

  import rsp_pkg::*;

  localparam int AW  = 2 * W;
  localparam int HW  = 2 * W + 1;
  localparam int R   = W + F;
  localparam int EW  = 1 + HW + R + AW;
  localparam int NW  = ((AW > R) ? AW : R) + 2;
  localparam int N2W = NW + F + 1;
  localparam int CW  = (N2W > AW + 1 + W) ? N2W : AW + 1 + W;

  localparam logic [W-1:0] MAXU = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINU = {1'b1, {(W-1){1'b0}}};

  logic          ben, issue, second, first_half;
  logic          e_sph;
  logic [HW-1:0] e_nh;
  logic [R-1:0]  e_root;
  logic [AW-1:0] e_den;
  logic [NW-1:0] nhx, rtx;

  logic          v0, v1, v2;
  logic          last0, last1, last2;
  logic [NW-1:0] num0, mag1;
  logic [AW-1:0] den0, den1;
  logic          sg1, sg2;
  logic [N2W-1:0] n2;
  logic [AW:0]   d2;

  logic [N2W-1:0] rem [0:W];
  logic [W-1:0]   q   [0:W];
  logic [AW:0]    d2s [0:W];
  logic [W:0]     dv, dsg, dlast, dsat;

  assign e_sph  = entry[EW-1];
  assign e_nh   = entry[EW-2 -: HW];
  assign e_root = entry[AW+R-1 -: R];
  assign e_den  = entry[AW-1:0];

  assign ben        = !out_valid || out_ready;
  assign issue      = ben && !status.empty;
  assign first_half = e_sph && !second;
  assign pop        = issue && !first_half;

  assign nhx = {{(NW-HW){e_nh[HW-1]}}, e_nh};
  assign rtx = NW'(e_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
      v0     <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else if (ben) begin
      if (issue) begin
        second <= first_half;
      end
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      last0 <= !first_half;
      num0  <= first_half ? nhx - rtx : nhx + rtx;
      den0  <= e_den;
      sg1   <= num0[NW-1];
      mag1  <= num0[NW-1] ? NW'(0) - num0 : num0;
      den1  <= den0;
      last1 <= last0;
      n2    <= (N2W'(mag1) << (F + 1)) + N2W'(den1);
      d2    <= {den1, 1'b0};
      sg2   <= sg1;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (ben) begin
      dv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      rem[0]   <= n2;
      q[0]     <= '0;
      d2s[0]   <= d2;
      dsg[0]   <= sg2;
      dlast[0] <= last2;
      dsat[0]  <= CW'(n2) >= (CW'(d2) << W);
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int I = W - 1 - k;
    logic [CW-1:0] dsh;
    logic          ge;

    assign dsh = CW'(d2s[k]) << I;
    assign ge  = CW'(rem[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (ben) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        rem[k+1]   <= ge ? N2W'(CW'(rem[k]) - dsh) : rem[k];
        q[k+1]     <= ge ? (q[k] | (W'(1) << I)) : q[k];
        d2s[k+1]   <= d2s[k];
        dsg[k+1]   <= dsg[k];
        dlast[k+1] <= dlast[k];
        dsat[k+1]  <= dsat[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ben) begin
      out_valid <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      last <= dlast[W];
      if (dsg[W]) begin
        t_value <= (dsat[W] || q[W] > MINU) ? MINU : (~q[W] + 1'b1);
      end else begin
        t_value <= (dsat[W] || q[W] > MAXU) ? MAXU : q[W];
      end
    end
  end

endmodule

// ----- rtl/rsp_checker.sv -----
// Port-level checks for the intersection core, attached by the bind at the end.
// It depends on rsp_pkg for the configuration data width.
module rsp_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [COORD_WIDTH-1:0]        t_value,
  input logic                          last,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rsp_pkg::EPS_WIDTH-1:0] cfg_data
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(t_value) && $stable(last))
    else $error("stalled result changed");

  // The second sphere hit follows right behind the first one.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last)
    else $error("first sphere hit not followed by the closing one");

  // Reset leaves no result pending and the input side open.
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("state left after reset");

  // The epsilon register takes every write.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind ray_sphere_plane_intersect_core rsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);
